[design/bty_pkg.sv]
// Shared types and constants for the BGRA to YUV 4:2:0 stream converter.
// Used by every module of the block; depends on nothing.
package bty_pkg;

  // Line geometry
  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_EVEN    = (MAX_WIDTH / 2) * 2;
  localparam int LINE_W      = 12;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int STORE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int SLOT_W      = $clog2(STORE_DEPTH);
  localparam logic [LINE_W-1:0] WIDTH_RESET = LINE_W'(640);
  localparam logic [LINE_W-1:0] WIDTH_MIN   = LINE_W'(2);

  // Queue depths
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  // BT.601 coefficients, 8-bit luma scale and 10-bit chroma scale
  localparam int Y_R  = 66;
  localparam int Y_G  = 129;
  localparam int Y_B  = 25;
  localparam int Y_OFFSET = 16;
  localparam int CB_B = 112;
  localparam int CB_G = 74;
  localparam int CB_R = 38;
  localparam int CR_R = 112;
  localparam int CR_G = 94;
  localparam int CR_B = 18;
  localparam int CHROMA_BIAS = 131072;   // 128 << 10
  localparam int CHROMA_W    = 19;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       start_of_frame;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
  } result_t;

  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } pair_sum_t;

  typedef enum logic [1:0] {
    CMD_LUMA_ONLY,
    CMD_STORE_PAIR,
    CMD_CHROMA
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
    pair_sum_t         sums;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } cmd_wr_t;

endpackage

[design/bty_front.sv]
// Front end: line width register, raster position tracking and pixel pairing.
// Classifies each pixel into a command for the back end. Uses bty_pkg.
module bty_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [bty_pkg::LINE_W-1:0]  cfg_data_i,
  output logic                        cfg_ready_o,
  input  logic                        push_i,
  input  bty_pkg::pixel_t             pixel_i,
  output bty_pkg::cmd_t               cmd_o,
  output bty_pkg::cmd_wr_t            cmd_wr_o,
  input  logic                        cmd_full_i
);

  logic [bty_pkg::LINE_W-1:0] line_width_q;
  logic [bty_pkg::LINE_W-1:0] width_even;
  logic [bty_pkg::LINE_W-1:0] width_eff;
  logic [bty_pkg::COL_W-1:0]  col_q, col_d, col_cur;
  logic                       odd_q, odd_d, odd_cur;
  logic [23:0]                held_q;
  logic [bty_pkg::LINE_W-1:0] col_next;
  logic                       accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = push_i && !cmd_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= bty_pkg::WIDTH_RESET;
    end else if (cfg_valid_i) begin
      line_width_q <= cfg_data_i;
    end
  end

  // Ignore bit 0, clamp to the supported range
  always_comb begin
    width_even = {line_width_q[bty_pkg::LINE_W-1:1], 1'b0};
    width_eff  = width_even;
    if (width_even > bty_pkg::LINE_W'(bty_pkg::MAX_EVEN)) begin
      width_eff = bty_pkg::LINE_W'(bty_pkg::MAX_EVEN);
    end
    if (width_even < bty_pkg::WIDTH_MIN) begin
      width_eff = bty_pkg::WIDTH_MIN;
    end
  end

  always_comb begin
    col_cur  = pixel_i.start_of_frame ? '0 : col_q;
    odd_cur  = pixel_i.start_of_frame ? 1'b0 : odd_q;
    col_next = bty_pkg::LINE_W'(col_cur) + bty_pkg::LINE_W'(1);
    col_d    = col_next[bty_pkg::COL_W-1:0];
    odd_d    = odd_cur;
    if (col_next >= width_eff) begin
      col_d = '0;
      odd_d = !odd_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      odd_q  <= 1'b0;
      held_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      odd_q <= odd_d;
      if (!col_cur[0]) begin
        held_q <= {pixel_i.red, pixel_i.green, pixel_i.blue};
      end
    end
  end

  always_comb begin
    cmd_o.blue       = pixel_i.blue;
    cmd_o.green      = pixel_i.green;
    cmd_o.red        = pixel_i.red;
    cmd_o.sums.blue  = 9'(pixel_i.blue)  + 9'(held_q[7:0]);
    cmd_o.sums.green = 9'(pixel_i.green) + 9'(held_q[15:8]);
    cmd_o.sums.red   = 9'(pixel_i.red)   + 9'(held_q[23:16]);
    cmd_o.slot       = col_cur[bty_pkg::COL_W-1:1];
    if (!col_cur[0]) begin
      cmd_o.kind = bty_pkg::CMD_LUMA_ONLY;
    end else if (odd_cur) begin
      cmd_o.kind = bty_pkg::CMD_CHROMA;
    end else begin
      cmd_o.kind = bty_pkg::CMD_STORE_PAIR;
    end
  end

  assign cmd_wr_o.push = accept;
  assign cmd_wr_o.full = cmd_full_i;

endmodule

[design/bty_cmd_queue.sv]
// Short command queue between the front end and the back end.
// Flop-based, fixed depth from bty_pkg.
module bty_cmd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bty_pkg::cmd_t    cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output bty_pkg::cmd_t    cmd_o,
  output logic             empty_o
);

  bty_pkg::cmd_t                 entries_q [bty_pkg::CMD_DEPTH];
  logic [bty_pkg::CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [bty_pkg::CMD_CNT_W-1:0] cnt_q, cnt_d;
  logic                          do_wr, do_rd;

  assign full_o  = (cnt_q == bty_pkg::CMD_CNT_W'(bty_pkg::CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = push_i && !full_o;
  assign do_rd   = pop_i && !empty_o;
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + bty_pkg::CMD_CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - bty_pkg::CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + bty_pkg::CMD_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + bty_pkg::CMD_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[design/bty_back.sv]
// Back end: pair-sum line memory, luma and chroma arithmetic, result queue.
// Two pipeline stages feed a small result queue. Uses bty_pkg.
module bty_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bty_pkg::cmd_t     cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output bty_pkg::result_t  result_o,
  output logic              empty_o,
  input  logic              pop_i
);

  // Line memory of pair sums from the even row
  bty_pkg::pair_sum_t pair_mem [bty_pkg::STORE_DEPTH];

  // Stage A
  logic                a_v_q;
  bty_pkg::cmd_kind_e  a_kind_q;
  bty_pkg::pair_sum_t  a_sum_q;
  bty_pkg::pair_sum_t  a_rd_q;
  logic [15:0]         a_luma_q;
  logic [15:0]         luma_prod;

  // Stage B
  logic                b_v_q;
  logic                b_chroma_q;
  logic [7:0]          b_luma_q;
  logic [9:0]          b_tb_q, b_tg_q, b_tr_q;

  // Chroma combine
  logic [bty_pkg::CHROMA_W-1:0] vu, vv;
  bty_pkg::result_t             res;

  // Result queue
  bty_pkg::result_t              out_q [bty_pkg::OUT_DEPTH];
  logic [bty_pkg::OUT_PTR_W-1:0] out_wr_q, out_rd_q;
  logic [bty_pkg::OUT_CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic [bty_pkg::OUT_CNT_W:0]   committed;
  logic                          out_pop;

  // Issue only when the result queue can absorb everything in flight
  assign committed = (bty_pkg::OUT_CNT_W+1)'(out_cnt_q)
                   + (bty_pkg::OUT_CNT_W+1)'(a_v_q)
                   + (bty_pkg::OUT_CNT_W+1)'(b_v_q);
  assign cmd_pop_o = !cmd_empty_i &&
                     (committed < (bty_pkg::OUT_CNT_W+1)'(bty_pkg::OUT_DEPTH));

  assign luma_prod = 16'(cmd_i.red)   * 16'(bty_pkg::Y_R)
                   + 16'(cmd_i.green) * 16'(bty_pkg::Y_G)
                   + 16'(cmd_i.blue)  * 16'(bty_pkg::Y_B);

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      if (cmd_i.kind == bty_pkg::CMD_STORE_PAIR) begin
        pair_mem[cmd_i.slot] <= cmd_i.sums;
      end
      a_rd_q   <= pair_mem[cmd_i.slot];
      a_kind_q <= cmd_i.kind;
      a_sum_q  <= cmd_i.sums;
      a_luma_q <= luma_prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      a_v_q <= cmd_pop_o;
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_v_q) begin
      b_luma_q   <= a_luma_q[15:8] + 8'(bty_pkg::Y_OFFSET);
      b_chroma_q <= (a_kind_q == bty_pkg::CMD_CHROMA);
      b_tb_q     <= 10'(a_sum_q.blue)  + 10'(a_rd_q.blue);
      b_tg_q     <= 10'(a_sum_q.green) + 10'(a_rd_q.green);
      b_tr_q     <= 10'(a_sum_q.red)   + 10'(a_rd_q.red);
    end
  end

  // The bias keeps both sums non-negative, so modular math gives the floor
  assign vu = bty_pkg::CHROMA_W'(b_tb_q) * bty_pkg::CHROMA_W'(bty_pkg::CB_B)
            + bty_pkg::CHROMA_W'(bty_pkg::CHROMA_BIAS)
            - bty_pkg::CHROMA_W'(b_tg_q) * bty_pkg::CHROMA_W'(bty_pkg::CB_G)
            - bty_pkg::CHROMA_W'(b_tr_q) * bty_pkg::CHROMA_W'(bty_pkg::CB_R);
  assign vv = bty_pkg::CHROMA_W'(b_tr_q) * bty_pkg::CHROMA_W'(bty_pkg::CR_R)
            + bty_pkg::CHROMA_W'(bty_pkg::CHROMA_BIAS)
            - bty_pkg::CHROMA_W'(b_tg_q) * bty_pkg::CHROMA_W'(bty_pkg::CR_G)
            - bty_pkg::CHROMA_W'(b_tb_q) * bty_pkg::CHROMA_W'(bty_pkg::CR_B);

  always_comb begin
    res.luma         = b_luma_q;
    res.chroma_valid = b_chroma_q;
    res.cb           = b_chroma_q ? vu[17:10] : 8'd0;
    res.cr           = b_chroma_q ? vv[17:10] : 8'd0;
  end

  assign empty_o  = (out_cnt_q == '0);
  assign out_pop  = pop_i && !empty_o;
  assign result_o = out_q[out_rd_q];

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (b_v_q && !out_pop) begin
      out_cnt_d = out_cnt_q + bty_pkg::OUT_CNT_W'(1);
    end else if (out_pop && !b_v_q) begin
      out_cnt_d = out_cnt_q - bty_pkg::OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      out_cnt_q <= out_cnt_d;
      if (b_v_q) begin
        out_wr_q <= out_wr_q + bty_pkg::OUT_PTR_W'(1);
      end
      if (out_pop) begin
        out_rd_q <= out_rd_q + bty_pkg::OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_v_q) begin
      out_q[out_wr_q] <= res;
    end
  end

endmodule

[design/bgra_to_yuv420_stream.sv]
// Top level of the BGRA to YUV 4:2:0 stream converter.
// Instantiates bty_front, bty_cmd_queue and bty_back; uses bty_pkg.
//
// Usage:
//   Pixels enter in raster order on the push side: a beat moves when push is
//   high and full is low. start_of_frame on a beat restarts at column 0 of an
//   even row. Each pixel yields one result beat: BT.601 luma, and on the odd
//   column of an odd row also Cb/Cr for the 2x2 block it completes.
//   Results leave on the pop side: the oldest result shows while empty is low
//   and moves when pop is high.
//   line_width is written on the cfg channel (ready is always high); write it
//   only while no pixel is in flight. Bit 0 is ignored, the value is clamped
//   to 2..2048. Reset leaves 640.
//   Pixels pass the command queue, stage A, stage B and the result queue at
//   one pixel per cycle unless pop stalls, with one line-memory read each.
//   Reset clears position, queues and pipeline; the line memory is not
//   cleared, since every odd row reads only entries its even row wrote.
//   When the receiver stalls, the 4-deep result queue fills, the pipeline
//   drains into it, the 4-deep command queue fills and then full rises.
module bgra_to_yuv420_stream (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  bty_pkg::pixel_t             pixel_i,
  output logic                        empty,
  input  logic                        pop,
  output bty_pkg::result_t            result_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bty_pkg::LINE_W-1:0]  cfg_data_i
);

  bty_pkg::cmd_t    front_cmd;
  bty_pkg::cmd_t    back_cmd;
  bty_pkg::cmd_wr_t cmd_wr;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;

  // Front: track position, pair pixels, classify
  bty_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .push_i      (push),
    .pixel_i     (pixel_i),
    .cmd_o       (front_cmd),
    .cmd_wr_o    (cmd_wr),
    .cmd_full_i  (cmd_full)
  );

  // Decouple front and back
  bty_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_wr.push),
    .cmd_i   (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .cmd_o   (back_cmd),
    .empty_o (cmd_empty)
  );

  // Back: line memory access, arithmetic, result queue
  bty_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .result_o    (result_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign full = cmd_wr.full;

endmodule

[design/bty_checker.sv]
// Port-level checker for bgra_to_yuv420_stream, attached with bind.
// Watches only the top level's ports; uses bty_pkg.
module bty_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic              full,
  input  logic              empty,
  input  logic              pop,
  input  bty_pkg::result_t  result_o,
  input  logic              cfg_ready_o
);

  logic [4:0] pending_q;
  logic       in_beat, out_beat;

  assign in_beat  = push && !full;
  assign out_beat = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_beat && !out_beat) begin
      pending_q <= pending_q + 5'd1;
    end else if (out_beat && !in_beat) begin
      pending_q <= pending_q - 5'd1;
    end
  end

  // No result without a pixel still owed one
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> pending_q != 5'd0)
    else $error("result beat with no pixel outstanding");

  // Chroma fields are zero outside completed blocks
  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.chroma_valid) |-> (result_o.cb == 8'd0 && result_o.cr == 8'd0))
    else $error("chroma nonzero without chroma_valid");

  // Luma stays in the studio range
  a_luma_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.luma >= 8'd16 && result_o.luma <= 8'd235))
    else $error("luma out of range");

  // A waiting result holds until taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed");

  // Configuration is always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("cfg_ready low");

endmodule

bind bgra_to_yuv420_stream bty_checker u_bty_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .result_o    (result_o),
  .cfg_ready_o (cfg_ready_o)
);
